/* sv/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros for the heading unit; they compile to nothing under SYNTHESIS.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define THC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("heading unit assertion failed");

`define THC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("heading unit assertion failed");

`else

`define THC_ASSERT_NOW(label, ante, cons)

`define THC_ASSERT_NEXT(label, ante, cons)

`endif

`endif

/* sv/thc_pkg.sv */
// ----------------------------------------------------------------------------
// thc_pkg
// Shared constants, word types and the arctangent table of the heading unit.
// ----------------------------------------------------------------------------
package thc_pkg;

    localparam int ANGLE_ITERATIONS = 16;
    localparam int CordicSteps      = (ANGLE_ITERATIONS < 32) ? ANGLE_ITERATIONS : 32;

    localparam int SqrtBits   = 28;     // root of |a|^2 * 2^24
    localparam int RemW       = 58;
    localparam int MagW       = 60;     // |X|, |Y| before normalization
    localparam int NormSteps  = 5;      // shifts of 16, 8, 4, 2, 1
    localparam int WorkBits   = 30;
    localparam int WorkW      = 34;     // CORDIC x, y with growth and sign
    localparam int AngW       = 32;

    localparam logic signed [AngW-1:0] HalfTurn = 32'sd11796480;
    localparam logic signed [AngW-1:0] FullTurn = 32'sd23592960;
    localparam logic [11:0]            TenthsTurn = 12'd3600;

    localparam int QueueDepth = 4;
    localparam int QueuePtrW  = 2;

    typedef struct packed {
        logic signed [32:0] ex;
        logic signed [32:0] ey;
        logic signed [32:0] ez;
        logic signed [15:0] ax;
        logic signed [15:0] az;
        logic [31:0]        amag2;
        logic               inv;
    } front_word_t;

    typedef struct packed {
        logic signed [49:0] ny;
        logic signed [32:0] ey;
        logic               inv;
    } sq_car_t;

    typedef struct packed {
        logic xneg;
        logic yneg;
        logic inv;
        logic force0;
    } ang_flag_t;

    function automatic logic signed [AngW-1:0] atan_entry(input int idx);
        logic signed [AngW-1:0] v;
        unique case (idx)
            0:  v = 32'sd2949120;
            1:  v = 32'sd1740967;
            2:  v = 32'sd919879;
            3:  v = 32'sd466945;
            4:  v = 32'sd234379;
            5:  v = 32'sd117304;
            6:  v = 32'sd58666;
            7:  v = 32'sd29335;
            8:  v = 32'sd14668;
            9:  v = 32'sd7334;
            10: v = 32'sd3667;
            11: v = 32'sd1833;
            12: v = 32'sd917;
            13: v = 32'sd458;
            14: v = 32'sd229;
            15: v = 32'sd115;
            16: v = 32'sd57;
            17: v = 32'sd29;
            18: v = 32'sd14;
            19: v = 32'sd7;
            20: v = 32'sd4;
            21: v = 32'sd2;
            22: v = 32'sd1;
            default: v = 32'sd0;
        endcase
        return v;
    endfunction

endpackage

/* sv/thc_sample_if.sv */
// ----------------------------------------------------------------------------
// thc_sample_if
// Sensor sample channel: magnetometer and accelerometer axes.
// ----------------------------------------------------------------------------
interface thc_sample_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] mag_x;
    logic signed [15:0] mag_y;
    logic signed [15:0] mag_z;
    logic signed [15:0] acc_x;
    logic signed [15:0] acc_y;
    logic signed [15:0] acc_z;

    modport source (output valid, mag_x, mag_y, mag_z, acc_x, acc_y, acc_z, input ready);
    modport sink   (input valid, mag_x, mag_y, mag_z, acc_x, acc_y, acc_z, output ready);
endinterface

/* sv/thc_result_if.sv */
// ----------------------------------------------------------------------------
// thc_result_if
// Heading result channel.
// ----------------------------------------------------------------------------
interface thc_result_if;
    logic        valid;
    logic        ready;
    logic [11:0] heading_tenths;
    logic        invalid;

    modport source (output valid, heading_tenths, invalid, input ready);
    modport sink   (input valid, heading_tenths, invalid, output ready);
endinterface

/* sv/thc_front.sv */
// ----------------------------------------------------------------------------
// thc_front
// Takes a sample word, forms E = m x a and |a|^2 and flags a zero E.
// ----------------------------------------------------------------------------
module thc_front (
    input  logic               clk,
    input  logic               rst_n,
    thc_sample_if.sink         sample,
    output thc_pkg::front_word_t word,
    output logic               word_valid,
    input  logic               word_ready
);
    import thc_pkg::*;

    logic               hold_valid_reg;
    logic signed [15:0] mx_reg, my_reg, mz_reg, ax_reg, ay_reg, az_reg;
    logic signed [31:0] p_ex_a, p_ex_b, p_ey_a, p_ey_b, p_ez_a, p_ez_b;
    logic signed [31:0] sq_x, sq_y, sq_z;
    logic               take;

    assign sample.ready = !hold_valid_reg || word_ready;
    assign take         = sample.valid && sample.ready;
    assign word_valid   = hold_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else if (take)
        begin
            hold_valid_reg <= 1'b1;
        end
        else if (word_ready)
        begin
            hold_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            mx_reg <= sample.mag_x;
            my_reg <= sample.mag_y;
            mz_reg <= sample.mag_z;
            ax_reg <= sample.acc_x;
            ay_reg <= sample.acc_y;
            az_reg <= sample.acc_z;
        end
    end

    always_comb
    begin
        p_ex_a = my_reg * az_reg;
        p_ex_b = mz_reg * ay_reg;
        p_ey_a = mz_reg * ax_reg;
        p_ey_b = mx_reg * az_reg;
        p_ez_a = mx_reg * ay_reg;
        p_ez_b = my_reg * ax_reg;
        sq_x   = ax_reg * ax_reg;
        sq_y   = ay_reg * ay_reg;
        sq_z   = az_reg * az_reg;

        word.ex    = $signed({p_ex_a[31], p_ex_a}) - $signed({p_ex_b[31], p_ex_b});
        word.ey    = $signed({p_ey_a[31], p_ey_a}) - $signed({p_ey_b[31], p_ey_b});
        word.ez    = $signed({p_ez_a[31], p_ez_a}) - $signed({p_ez_b[31], p_ez_b});
        word.ax    = ax_reg;
        word.az    = az_reg;
        word.amag2 = sq_x[31:0] + sq_y[31:0] + sq_z[31:0];
        word.inv   = (word.ex == 33'sd0) && (word.ey == 33'sd0) && (word.ez == 33'sd0);
    end

endmodule

/* sv/thc_queue.sv */
// ----------------------------------------------------------------------------
// thc_queue
// Small FIFO of front words between the front and back parts.
// ----------------------------------------------------------------------------
module thc_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  thc_pkg::front_word_t push_word,
    input  logic                 push_valid,
    output logic                 push_ready,
    output thc_pkg::front_word_t pop_word,
    output logic                 pop_valid,
    input  logic                 pop_ready
);
    import thc_pkg::*;

    front_word_t            mem [0:QueueDepth-1];
    logic [QueuePtrW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [QueuePtrW:0]     count_reg;
    logic                   do_push, do_pop;

    assign push_ready = (count_reg != (QueuePtrW+1)'(QueueDepth));
    assign pop_valid  = (count_reg != '0);
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;
    assign pop_word   = mem[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_word;
        end
    end

endmodule

/* sv/thc_back.sv */
// ----------------------------------------------------------------------------
// thc_back
// Heading pipeline: N_y, restoring root of |a|^2 one bit a stage, scaling, normalization,
// vectoring CORDIC, quadrant fold and conversion to tenths of a degree.
// ----------------------------------------------------------------------------
module thc_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  thc_pkg::front_word_t word,
    input  logic                 word_valid,
    output logic                 word_ready,
    thc_result_if.source         result
);
    import thc_pkg::*;

    logic ce;

    // root stages
    logic                 q_valid_reg [0:SqrtBits];
    logic [RemW-1:0]      q_rem_reg   [0:SqrtBits];
    logic [SqrtBits-1:0]  q_root_reg  [0:SqrtBits];
    sq_car_t              q_car_reg   [0:SqrtBits];

    // normalization stages, index 0 is the scaling stage
    logic                 n_valid_reg [0:NormSteps];
    logic [MagW-1:0]      n_x_reg     [0:NormSteps];
    logic [MagW-1:0]      n_y_reg     [0:NormSteps];
    ang_flag_t            n_flag_reg  [0:NormSteps];

    // CORDIC stages
    logic                     c_valid_reg [0:CordicSteps];
    logic signed [WorkW-1:0]  c_x_reg     [0:CordicSteps];
    logic signed [WorkW-1:0]  c_y_reg     [0:CordicSteps];
    logic signed [AngW-1:0]   c_z_reg     [0:CordicSteps];
    ang_flag_t                c_flag_reg  [0:CordicSteps];

    logic        f_valid_reg;
    logic [24:0] f_ang_reg;
    ang_flag_t   f_flag_reg;

    logic        out_valid_reg;
    logic [11:0] heading_reg;
    logic        invalid_reg;

    logic signed [48:0] ny_pa, ny_pb;
    logic signed [32:0] ey_abs;
    logic signed [49:0] ny_abs;
    logic [MagW-1:0]    y_prod;
    logic signed [AngW-1:0] a_fold, a_lo, a_hi, a_wrap;
    logic [28:0]        t_scaled;
    logic [11:0]        t_raw, t_fix;

    assign ce         = !out_valid_reg || result.ready;
    assign word_ready = ce;

    // ---------------- load: N_y and root seed ----------------
    always_comb
    begin
        ny_pa = word.az * word.ex;
        ny_pb = word.ax * word.ez;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_valid_reg[0] <= 1'b0;
        end
        else if (ce)
        begin
            q_valid_reg[0] <= word_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            q_rem_reg[0]     <= {2'b00, word.amag2, 24'd0};
            q_root_reg[0]    <= '0;
            q_car_reg[0].ny  <= $signed({ny_pa[48], ny_pa}) - $signed({ny_pb[48], ny_pb});
            q_car_reg[0].ey  <= word.ey;
            q_car_reg[0].inv <= word.inv;
        end
    end

    // ---------------- restoring square root, one bit a stage ----------------
    for (genvar j = 0; j < SqrtBits; j++)
    begin : g_sqrt
        localparam int B = SqrtBits - 1 - j;
        logic [RemW-1:0] cand;
        logic            ge;

        always_comb
        begin
            cand = (RemW'(q_root_reg[j]) << (B + 1)) + (RemW'(1) << (2 * B));
            ge   = (q_rem_reg[j] >= cand);
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                q_valid_reg[j+1] <= 1'b0;
            end
            else if (ce)
            begin
                q_valid_reg[j+1] <= q_valid_reg[j];
            end
        end

        always_ff @(posedge clk)
        begin
            if (ce)
            begin
                q_rem_reg[j+1]  <= ge ? (q_rem_reg[j] - cand) : q_rem_reg[j];
                q_root_reg[j+1] <= ge ? (q_root_reg[j] | (SqrtBits'(1) << B)) : q_root_reg[j];
                q_car_reg[j+1]  <= q_car_reg[j];
            end
        end
    end

    // ---------------- scaling: X = |N_y| * 2^12, Y = |E_y| * S ----------------
    always_comb
    begin
        ey_abs = q_car_reg[SqrtBits].ey[32] ? -q_car_reg[SqrtBits].ey : q_car_reg[SqrtBits].ey;
        ny_abs = q_car_reg[SqrtBits].ny[49] ? -q_car_reg[SqrtBits].ny : q_car_reg[SqrtBits].ny;
        y_prod = ey_abs[31:0] * q_root_reg[SqrtBits];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_valid_reg[0] <= 1'b0;
        end
        else if (ce)
        begin
            n_valid_reg[0] <= q_valid_reg[SqrtBits];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            n_x_reg[0]             <= {ny_abs[47:0], 12'd0};
            n_y_reg[0]             <= y_prod;
            n_flag_reg[0].xneg     <= (q_car_reg[SqrtBits].ny > 50'sd0);
            n_flag_reg[0].yneg     <= (q_car_reg[SqrtBits].ey > 33'sd0);
            n_flag_reg[0].inv      <= q_car_reg[SqrtBits].inv;
            n_flag_reg[0].force0   <= q_car_reg[SqrtBits].inv
                                      || ((q_car_reg[SqrtBits].ny == 50'sd0)
                                      && ((q_car_reg[SqrtBits].ey == 33'sd0)
                                      || (q_root_reg[SqrtBits] == '0)));
        end
    end

    // ---------------- joint normalization below 2^30 ----------------
    for (genvar k = 0; k < NormSteps; k++)
    begin : g_norm
        localparam int Step = 1 << (NormSteps - 1 - k);
        logic hit;

        assign hit = ((n_x_reg[k] | n_y_reg[k]) >> (WorkBits - 1 + Step)) != '0;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                n_valid_reg[k+1] <= 1'b0;
            end
            else if (ce)
            begin
                n_valid_reg[k+1] <= n_valid_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (ce)
            begin
                n_x_reg[k+1]    <= hit ? (n_x_reg[k] >> Step) : n_x_reg[k];
                n_y_reg[k+1]    <= hit ? (n_y_reg[k] >> Step) : n_y_reg[k];
                n_flag_reg[k+1] <= n_flag_reg[k];
            end
        end
    end

    // ---------------- vectoring CORDIC ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_valid_reg[0] <= 1'b0;
        end
        else if (ce)
        begin
            c_valid_reg[0] <= n_valid_reg[NormSteps];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            c_x_reg[0]    <= $signed({(WorkW-WorkBits)'(0), n_x_reg[NormSteps][WorkBits-1:0]});
            c_y_reg[0]    <= $signed({(WorkW-WorkBits)'(0), n_y_reg[NormSteps][WorkBits-1:0]});
            c_z_reg[0]    <= '0;
            c_flag_reg[0] <= n_flag_reg[NormSteps];
        end
    end

    for (genvar i = 0; i < CordicSteps; i++)
    begin : g_cordic
        localparam logic signed [AngW-1:0] Atan = atan_entry(i);
        logic signed [WorkW-1:0] dx, dy;
        logic                    cw;

        always_comb
        begin
            dx = c_y_reg[i] >>> i;
            dy = c_x_reg[i] >>> i;
            cw = !c_y_reg[i][WorkW-1];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                c_valid_reg[i+1] <= 1'b0;
            end
            else if (ce)
            begin
                c_valid_reg[i+1] <= c_valid_reg[i];
            end
        end

        always_ff @(posedge clk)
        begin
            if (ce)
            begin
                c_x_reg[i+1]    <= cw ? (c_x_reg[i] + dx) : (c_x_reg[i] - dx);
                c_y_reg[i+1]    <= cw ? (c_y_reg[i] - dy) : (c_y_reg[i] + dy);
                c_z_reg[i+1]    <= cw ? (c_z_reg[i] + Atan) : (c_z_reg[i] - Atan);
                c_flag_reg[i+1] <= c_flag_reg[i];
            end
        end
    end

    // ---------------- quadrant fold and wrap ----------------
    always_comb
    begin
        unique case ({c_flag_reg[CordicSteps].xneg, c_flag_reg[CordicSteps].yneg})
            2'b00:   a_fold = c_z_reg[CordicSteps];
            2'b10:   a_fold = HalfTurn - c_z_reg[CordicSteps];
            2'b11:   a_fold = HalfTurn + c_z_reg[CordicSteps];
            default: a_fold = FullTurn - c_z_reg[CordicSteps];
        endcase
        a_lo   = a_fold[AngW-1] ? (a_fold + FullTurn) : a_fold;
        a_hi   = (a_lo >= FullTurn) ? (a_lo - FullTurn) : a_lo;
        a_wrap = a_hi[AngW-1] ? '0 : a_hi;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_valid_reg <= 1'b0;
        end
        else if (ce)
        begin
            f_valid_reg <= c_valid_reg[CordicSteps];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            f_ang_reg  <= a_wrap[24:0];
            f_flag_reg <= c_flag_reg[CordicSteps];
        end
    end

    // ---------------- tenths of a degree ----------------
    always_comb
    begin
        t_scaled = (29'(f_ang_reg) << 3) + (29'(f_ang_reg) << 1) + 29'd32768;
        t_raw    = t_scaled[27:16];
        t_fix    = (t_raw >= TenthsTurn) ? (t_raw - TenthsTurn) : t_raw;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ce)
        begin
            out_valid_reg <= f_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            heading_reg <= f_flag_reg.force0 ? 12'd0 : t_fix;
            invalid_reg <= f_flag_reg.inv;
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.heading_tenths = heading_reg;
    assign result.invalid        = invalid_reg;

endmodule

/* sv/tilt_compensated_heading_unit.sv */
// ----------------------------------------------------------------------------
// tilt_compensated_heading_unit
// Tilt-compensated compass heading from one magnetometer/accelerometer pair.
//
//   channel   dir   word
//   sample    in    mag_x/y/z, acc_x/y/z (signed 16 bit)
//   result    out   heading_tenths (12 bit, 0..3599), invalid
//
// One sample word per cycle sustained while results are taken; one result per sample.
// The back pipeline is load, the 28-stage root pipeline, scaling, normalization,
// one stage per CORDIC step, quadrant fold and conversion to tenths.
// Async active-low reset clears all valid bits; no clearing pass.
// A result stall freezes the back pipeline; the 4-word queue and the front
// register keep taking samples until they fill.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tilt_compensated_heading_unit (
    input  logic          clk,
    input  logic          rst_n,
    thc_sample_if.sink    sample,
    thc_result_if.source  result
);
    import thc_pkg::*;

    front_word_t front_word, queue_word;
    logic        front_valid, front_ready;
    logic        queue_valid, queue_ready;

    thc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .sample     (sample),
        .word       (front_word),
        .word_valid (front_valid),
        .word_ready (front_ready)
    );

    thc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_word  (front_word),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .pop_word   (queue_word),
        .pop_valid  (queue_valid),
        .pop_ready  (queue_ready)
    );

    thc_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .word       (queue_word),
        .word_valid (queue_valid),
        .word_ready (queue_ready),
        .result     (result)
    );

    `THC_ASSERT_NOW(a_invalid_zero, result.valid && result.invalid, result.heading_tenths == 12'd0)
    `THC_ASSERT_NOW(a_heading_range, result.valid, result.heading_tenths < 12'd3600)
    `THC_ASSERT_NEXT(a_result_drains, result.valid && result.ready && !queue_valid && !front_valid, sample.ready)

endmodule
